>>> src/lcmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmt_pkg
// shared types and constants for the min-line tree
// ----------------------------------------------------------------------------
package lcmt_pkg;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_PUSH  = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   localparam logic signed [63:0] LINE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] LINE_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [63:0] intercept;
   } node_type;

   localparam node_type NODE_EMPTY = '{slope: 32'sd0, intercept: LINE_MAX};

endpackage

>>> src/li_chao_min_line_tree_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// li_chao_min_line_tree_top
// li chao tree over a fixed x table, lower envelope of pushed lines
// ----------------------------------------------------------------------------
// One item at a time, one shared two-stage line evaluator under a small
// sequencer. After reset the block sweeps all 2*NUM_POINTS node entries,
// one node a cycle, and only then raises req_ready. A load is written to
// the x table as it is accepted. A query walks from leaf to root over
// log2(NUM_POINTS)+1 nodes, each through Q_X, Q_EV, Q_W1 and Q_W2, then
// hands its result over in Q_OUT. A push splits its range into at most
// 2*log2(NUM_POINTS) cover nodes; each descends at most log2(NUM_POINTS)+1
// levels after setup in D_INIT and D_SHIFT, and each level makes three x
// reads and six line evaluations through the single evaluator, then the
// decision in D_DEC. Only a query gives a result item; the result register
// frees req_ready as soon as the query has been handed over to it.
// ----------------------------------------------------------------------------
module li_chao_min_line_tree_top #(
   parameter int NUM_POINTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [9:0]         req_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_slope,
   input  logic signed [63:0] req_intercept,
   input  logic [10:0]        req_range_lo,
   input  logic [10:0]        req_range_hi,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_min_value
);
   import lcmt_pkg::*;

   localparam int LG = $clog2(NUM_POINTS);
   localparam int CW = LG + 2;   // leaf-level bounds, up to 2N
   localparam int NW = LG + 3;   // node index, may step past 2N-1

   typedef enum logic [19:0] {
      ST_CLR     = 20'h00001,
      ST_IDLE    = 20'h00002,
      ST_C_LEFT  = 20'h00004,
      ST_C_RIGHT = 20'h00008,
      ST_C_SHIFT = 20'h00010,
      ST_D_INIT  = 20'h00020,
      ST_D_SHIFT = 20'h00040,
      ST_D_CHECK = 20'h00080,
      ST_P_XRD   = 20'h00100,
      ST_P_EVO   = 20'h00200,
      ST_P_EVN   = 20'h00400,
      ST_P_W1    = 20'h00800,
      ST_P_W2    = 20'h01000,
      ST_D_DEC   = 20'h02000,
      ST_Q_X     = 20'h04000,
      ST_Q_EV    = 20'h08000,
      ST_Q_W1    = 20'h10000,
      ST_Q_W2    = 20'h20000,
      ST_Q_OUT   = 20'h40000
   } state_type;

   // memories
   logic signed [31:0] x_mem [NUM_POINTS];
   node_type           node_mem [2*NUM_POINTS];

   state_type state_ff, state_in;

   // sequencer registers
   logic [LG:0]        clr_ff, clr_in;
   logic [CW-1:0]      cl_ff, cl_in, cr_ff, cr_in;   // cover loop bounds
   logic [CW-1:0]      dl_ff, dl_in, dr_ff, dr_in;   // descent leaf bounds
   logic [NW-1:0]      node_ff, node_in;
   logic               ret_right_ff, ret_right_in;   // return to right check
   logic [1:0]         pt_ff, pt_in;                 // point: left, mid, right
   logic signed [31:0] push_a_ff, push_a_in;
   logic signed [63:0] push_b_ff, push_b_in;
   logic signed [31:0] cur_a_ff, cur_a_in;
   logic signed [63:0] cur_b_ff, cur_b_in;
   logic signed [63:0] yo_ff [3];
   logic signed [63:0] yn_ff [3];
   logic [LG-1:0]      qidx_ff, qidx_in;
   logic signed [63:0] ymin_ff, ymin_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [63:0] rsp_min_value_ff, rsp_min_value_in;

   // memory read data
   logic signed [31:0] xrd_ff;
   node_type           nrd_ff;

   logic               accept;
   logic [LG-1:0]      x_addr;
   logic [CW:0]        mid_sum;
   logic [CW-1:0]      mid;
   logic               node_we;
   logic [LG:0]        node_waddr;
   node_type           node_wdata;
   logic signed [31:0] ev_a;
   logic signed [63:0] ev_b;
   logic signed [63:0] ev_y;
   logic               in_query;
   logic [31:0]        lo_wide, hi_wide;
   logic [CW-1:0]      lo_c, hi_c;
   logic               mid_new, right_new;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   assign mid_sum = {1'b0, dl_ff} + {1'b0, dr_ff};
   assign mid     = mid_sum[CW:1];

   // x address: query leaf, or the current sample point of a descent
   assign in_query = (state_ff == ST_Q_X) || (state_ff == ST_Q_EV) ||
                     (state_ff == ST_Q_W1) || (state_ff == ST_Q_W2);
   always_comb begin
      if (in_query) begin
         x_addr = qidx_ff;
      end else begin
         case (pt_ff)
            2'd0:    x_addr = dl_ff[LG-1:0];
            2'd1:    x_addr = mid[LG-1:0];
            default: x_addr = dr_ff[LG-1:0] - LG'(1);
         endcase
      end
   end

   // clamp of the push range to the table size
   assign lo_wide = (32'(req_range_lo) > 32'(NUM_POINTS)) ? 32'(NUM_POINTS)
                                                         : 32'(req_range_lo);
   assign hi_wide = (32'(req_range_hi) > 32'(NUM_POINTS)) ? 32'(NUM_POINTS)
                                                         : 32'(req_range_hi);
   assign lo_c = CW'(lo_wide);
   assign hi_c = CW'(hi_wide);

   // shared evaluator: stored line, except for the line being pushed
   assign ev_a = (state_ff == ST_P_EVN) ? cur_a_ff : nrd_ff.slope;
   assign ev_b = (state_ff == ST_P_EVN) ? cur_b_ff : nrd_ff.intercept;

   lcmt_line_eval u_line_eval (
      .clock     (clock),
      .slope     (ev_a),
      .intercept (ev_b),
      .x_value   (xrd_ff),
      .y_value   (ev_y)
   );

   // decision terms at the end of a level
   assign mid_new   = yn_ff[1] < yo_ff[1];
   assign right_new = (yo_ff[0] < yn_ff[0]) && (yn_ff[2] < yo_ff[2]);

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      cl_in            = cl_ff;
      cr_in            = cr_ff;
      dl_in            = dl_ff;
      dr_in            = dr_ff;
      node_in          = node_ff;
      ret_right_in     = ret_right_ff;
      pt_in            = pt_ff;
      push_a_in        = push_a_ff;
      push_b_in        = push_b_ff;
      cur_a_in         = cur_a_ff;
      cur_b_in         = cur_b_ff;
      qidx_in          = qidx_ff;
      ymin_in          = ymin_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_min_value_in = rsp_min_value_ff;
      node_we          = 1'b0;
      node_waddr       = node_ff[LG:0];
      node_wdata       = '{slope: cur_a_ff, intercept: cur_b_ff};

      case (state_ff)
         ST_CLR: begin
            node_we    = 1'b1;
            node_waddr = clr_ff;
            node_wdata = NODE_EMPTY;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_PUSH) begin
                  push_a_in = req_slope;
                  push_b_in = req_intercept;
                  cl_in     = lo_c + CW'(NUM_POINTS);
                  cr_in     = hi_c + CW'(NUM_POINTS);
                  state_in  = ST_C_LEFT;
               end else if (req_func == FUNC_QUERY) begin
                  qidx_in  = LG'(req_index);
                  node_in  = NW'(NUM_POINTS) + NW'(LG'(req_index));
                  ymin_in  = LINE_MAX;
                  state_in = ST_Q_X;
               end
            end
         end
         // bottom-up segment cover
         ST_C_LEFT: begin
            if (cl_ff >= cr_ff) begin
               state_in = ST_IDLE;
            end else if (cl_ff[0]) begin
               node_in      = NW'(cl_ff);
               cl_in        = cl_ff + 1'b1;
               ret_right_in = 1'b1;
               state_in     = ST_D_INIT;
            end else begin
               state_in = ST_C_RIGHT;
            end
         end
         ST_C_RIGHT: begin
            if (cr_ff[0]) begin
               node_in      = NW'(cr_ff) - NW'(1);
               cr_in        = cr_ff - 1'b1;
               ret_right_in = 1'b0;
               state_in     = ST_D_INIT;
            end else begin
               state_in = ST_C_SHIFT;
            end
         end
         ST_C_SHIFT: begin
            cl_in    = cl_ff >> 1;
            cr_in    = cr_ff >> 1;
            state_in = ST_C_LEFT;
         end
         // descent into one cover node
         ST_D_INIT: begin
            dl_in    = CW'(node_ff);
            dr_in    = CW'(node_ff) + CW'(1);
            cur_a_in = push_a_ff;
            cur_b_in = push_b_ff;
            state_in = ST_D_SHIFT;
         end
         ST_D_SHIFT: begin
            if (dl_ff < CW'(NUM_POINTS)) begin
               dl_in = dl_ff << 1;
               dr_in = dr_ff << 1;
            end else begin
               state_in = ST_D_CHECK;
            end
         end
         ST_D_CHECK: begin
            pt_in = 2'd0;
            if ((dl_ff < dr_ff) && (node_ff < NW'(2*NUM_POINTS))) begin
               state_in = ST_P_XRD;
            end else begin
               state_in = ret_right_ff ? ST_C_RIGHT : ST_C_SHIFT;
            end
         end
         ST_P_XRD: state_in = ST_P_EVO;
         ST_P_EVO: state_in = ST_P_EVN;
         ST_P_EVN: state_in = ST_P_W1;
         ST_P_W1:  state_in = ST_P_W2;
         ST_P_W2: begin
            if (pt_ff == 2'd2) begin
               state_in = ST_D_DEC;
            end else begin
               pt_in    = pt_ff + 1'b1;
               state_in = ST_P_XRD;
            end
         end
         ST_D_DEC: begin
            if ((yo_ff[0] < yn_ff[0]) && (yo_ff[2] < yn_ff[2])) begin
               state_in = ret_right_ff ? ST_C_RIGHT : ST_C_SHIFT;
            end else if ((yn_ff[0] < yo_ff[0]) && (yn_ff[2] < yo_ff[2])) begin
               node_we  = 1'b1;
               state_in = ret_right_ff ? ST_C_RIGHT : ST_C_SHIFT;
            end else begin
               if (mid_new) begin
                  // winner stays, the old line goes on down
                  node_we  = 1'b1;
                  cur_a_in = nrd_ff.slope;
                  cur_b_in = nrd_ff.intercept;
               end
               if (right_new != mid_new) begin
                  dl_in   = mid;
                  node_in = {node_ff[NW-2:0], 1'b1};
               end else begin
                  dr_in   = mid;
                  node_in = {node_ff[NW-2:0], 1'b0};
               end
               state_in = ST_D_CHECK;
            end
         end
         // leaf-to-root minimum
         ST_Q_X:  state_in = ST_Q_EV;
         ST_Q_EV: state_in = ST_Q_W1;
         ST_Q_W1: state_in = ST_Q_W2;
         ST_Q_W2: begin
            if (ev_y < ymin_ff) begin
               ymin_in = ev_y;
            end
            node_in  = node_ff >> 1;
            state_in = (node_ff == NW'(1)) ? ST_Q_OUT : ST_Q_X;
         end
         ST_Q_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_min_value_in = ymin_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cl_ff            <= cl_in;
      cr_ff            <= cr_in;
      dl_ff            <= dl_in;
      dr_ff            <= dr_in;
      node_ff          <= node_in;
      ret_right_ff     <= ret_right_in;
      pt_ff            <= pt_in;
      push_a_ff        <= push_a_in;
      push_b_ff        <= push_b_in;
      cur_a_ff         <= cur_a_in;
      cur_b_ff         <= cur_b_in;
      qidx_ff          <= qidx_in;
      ymin_ff          <= ymin_in;
      rsp_min_value_ff <= rsp_min_value_in;
      if (state_ff == ST_P_W1) begin
         yo_ff[pt_ff] <= ev_y;
      end
      if (state_ff == ST_P_W2) begin
         yn_ff[pt_ff] <= ev_y;
      end
   end

   // x table: one write port for loads, one registered read
   always_ff @(posedge clock) begin
      if (accept && (req_func == FUNC_LOAD)) begin
         x_mem[LG'(req_index)] <= req_x_value;
      end
      xrd_ff <= x_mem[x_addr];
   end

   // node store: one write port, one registered read at the current node
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      nrd_ff <= node_mem[node_ff[LG:0]];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_value_ff;

endmodule

>>> src/lcmt_line_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmt_line_eval
// two-stage line evaluator: y = a*x + b, saturated to 64 bits
// ----------------------------------------------------------------------------
module lcmt_line_eval (
   input  logic               clock,
   input  logic signed [31:0] slope,
   input  logic signed [63:0] intercept,
   input  logic signed [31:0] x_value,
   output logic signed [63:0] y_value
);
   import lcmt_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [63:0] icpt_ff;
   logic signed [63:0] y_ff;
   logic signed [63:0] y_in;
   logic        [64:0] sum;

   // stage 1: exact product
   assign prod_in = slope * x_value;

   // stage 2: add with clamp on signed overflow
   always_comb begin
      sum = {prod_ff[63], prod_ff} + {icpt_ff[63], icpt_ff};
      if (sum[64] != sum[63]) begin
         y_in = sum[64] ? LINE_MIN : LINE_MAX;
      end else begin
         y_in = sum[63:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      icpt_ff <= intercept;
      y_ff    <= y_in;
   end

   assign y_value = y_ff;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the li chao min-line tree
// ----------------------------------------------------------------------------
// Loads x coordinates, pushes lines over index ranges and queries the
// lower envelope. An in-bench tree mirrors every accepted item and predicts
// each query answer, which is compared with the block's result items in
// order. The sender idles in bursts, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import lcmt_pkg::*;

   localparam int NPTS  = 1024;
   localparam int NNODE = 2 * NPTS;
   localparam longint IC_TOP = 64'sd4611686018427387904;   // 2^62

   // mirror of the tree plus the queue of answers still owed by the block
   class envelope_board;
      longint x_tab[NPTS];
      longint n_slope[NNODE];
      longint n_icpt[NNODE];
      longint owed_min[$];
      int     errors;

      function new();
         for (int k = 0; k < NNODE; k++) begin
            n_slope[k] = 0;
            n_icpt[k]  = LINE_MAX;
         end
         foreach (x_tab[k]) x_tab[k] = 0;
         errors = 0;
      endfunction

      // a*x+b, saturated to 64 bits
      function longint eval_line(longint a, longint b, longint x);
         longint p;
         p = a * x;
         if (b > 0 && p > LINE_MAX - b) return LINE_MAX;
         if (b < 0 && p < LINE_MIN - b) return LINE_MIN;
         return p + b;
      endfunction

      function longint leaf_x(int unsigned leaf);
         return x_tab[(leaf - NPTS) & (NPTS - 1)];
      endfunction

      // keep the midpoint winner in the node, send the loser down one half
      function void sink_line(int unsigned node, longint a, longint b);
         int unsigned l, r, m;
         longint a0, b0, yl0, ym0, yr0, yl, ym, yr;
         bit mid_new, right_new;
         l = node;
         r = node + 1;
         while (l < NPTS) begin
            l = l << 1;
            r = r << 1;
         end
         while (l < r && node < NNODE) begin
            m   = (l + r) >> 1;
            a0  = n_slope[node];
            b0  = n_icpt[node];
            yl0 = eval_line(a0, b0, leaf_x(l));
            ym0 = eval_line(a0, b0, leaf_x(m));
            yr0 = eval_line(a0, b0, leaf_x(r - 1));
            yl  = eval_line(a, b, leaf_x(l));
            ym  = eval_line(a, b, leaf_x(m));
            yr  = eval_line(a, b, leaf_x(r - 1));
            if (yl0 < yl && yr0 < yr) return;
            if (yl < yl0 && yr < yr0) begin
               n_slope[node] = a;
               n_icpt[node]  = b;
               return;
            end
            mid_new = ym < ym0;
            if (mid_new) begin
               n_slope[node] = a;
               n_icpt[node]  = b;
               a = a0;
               b = b0;
            end
            right_new = (yl0 < yl) && (yr < yr0);
            if (right_new != mid_new) begin
               l    = m;
               node = (node << 1) | 1;
            end else begin
               r    = m;
               node = node << 1;
            end
         end
      endfunction

      function void note_item(func_type f, logic [9:0] idx, logic signed [31:0] xv,
                              logic signed [31:0] a, logic signed [63:0] b,
                              logic [10:0] lo, logic [10:0] hi);
         int unsigned l, r, node;
         longint y, v, x;
         case (f)
            FUNC_LOAD: begin
               x_tab[idx] = xv;
            end
            FUNC_PUSH: begin
               l = (lo > NPTS) ? NPTS : lo;
               r = (hi > NPTS) ? NPTS : hi;
               if (l < r) begin
                  for (l = l + NPTS, r = r + NPTS; l < r; l >>= 1, r >>= 1) begin
                     if (l & 1) begin
                        sink_line(l, a, b);
                        l++;
                     end
                     if (r & 1) begin
                        r--;
                        sink_line(r, a, b);
                     end
                  end
               end
            end
            FUNC_QUERY: begin
               x = x_tab[idx];
               y = LINE_MAX;
               node = idx + NPTS;
               while (node > 0) begin
                  v = eval_line(n_slope[node], n_icpt[node], x);
                  if (v < y) y = v;
                  node = node >> 1;
               end
               owed_min.push_back(y);
            end
            default: ;
         endcase
      endfunction

      function void check_min(logic signed [63:0] got);
         longint want;
         if (owed_min.size() == 0) begin
            $error("unexpected result item, min_value %0d", got);
            errors++;
            return;
         end
         want = owed_min.pop_front();
         if (got !== want) begin
            $error("min_value mismatch: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_func;
   logic [9:0]         req_index;
   logic signed [31:0] req_x_value;
   logic signed [31:0] req_slope;
   logic signed [63:0] req_intercept;
   logic [10:0]        req_range_lo;
   logic [10:0]        req_range_hi;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [63:0] rsp_min_value;

   envelope_board board = new();

   // which x entries hold a value; pushes and queries stay on those
   bit loaded[NPTS];
   int fill_up;       // next entry of the upward fill
   int fill_down;     // next entry of the downward fill
   int burst_left;

   li_chao_min_line_tree_top #(.NUM_POINTS(NPTS)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_index     (req_index),
      .req_x_value   (req_x_value),
      .req_slope     (req_slope),
      .req_intercept (req_intercept),
      .req_range_lo  (req_range_lo),
      .req_range_hi  (req_range_hi),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_min_value (rsp_min_value)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver stall pattern: a rotating 16-bit mask, renewed when stall_age wraps,
   // sometimes all ones so long stretches run with no stall
   logic [15:0] stall_mask;
   logic [7:0]  stall_age;
   initial begin
      stall_mask = 16'hFFFF;
      stall_age  = 8'd0;
      rsp_ready  = 1'b0;
   end
   always @(posedge clock) begin
      stall_age <= stall_age + 8'd1;
      if (stall_age == 8'd255)
         stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      else
         stall_mask <= {stall_mask[14:0], stall_mask[15]};
      rsp_ready <= stall_mask[0];
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_min(rsp_min_value);
   end

   // hold one item on the request channel until it is taken
   task automatic send_item(input func_type f, input logic [9:0] idx,
                            input logic signed [31:0] xv, input logic signed [31:0] a,
                            input logic signed [63:0] b, input logic [10:0] lo,
                            input logic [10:0] hi);
      int gap;
      // new burst: drop valid for a random gap first
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 10);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_index     <= idx;
      req_x_value   <= xv;
      req_slope     <= a;
      req_intercept <= b;
      req_range_lo  <= lo;
      req_range_hi  <= hi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(f, idx, xv, a, b, lo, hi);
      if (f == FUNC_LOAD) loaded[idx] = 1'b1;
      burst_left--;
   endtask

   task automatic load_x(input int idx, input logic signed [31:0] xv);
      send_item(FUNC_LOAD, 10'(idx), xv, 32'($urandom), 64'({$urandom, $urandom}),
                11'($urandom), 11'($urandom));
   endtask

   task automatic push_line(input logic signed [31:0] a, input logic signed [63:0] b,
                            input int lo, input int hi);
      send_item(FUNC_PUSH, 10'($urandom), 32'($urandom), a, b, 11'(lo), 11'(hi));
   endtask

   task automatic query_min(input int idx);
      send_item(FUNC_QUERY, 10'(idx), 32'($urandom), 32'($urandom),
                64'({$urandom, $urandom}), 11'($urandom), 11'($urandom));
   endtask

   function automatic logic signed [31:0] rand_slope();
      case ($urandom_range(0, 3))
         0:       return 32'($urandom);
         1:       return 32'($signed($urandom_range(0, 200)) - 100);
         default: return 32'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   // intercepts stay within +-2^62
   function automatic logic signed [63:0] rand_icpt();
      logic signed [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0:       return raw >>> 1 >>> 1;
         1:       return raw >>> 20;
         default: return raw >>> 40;
      endcase
   endfunction

   function automatic int pick_loaded();
      int k;
      for (int t = 0; t < 16; t++) begin
         k = $urandom_range(0, NPTS - 1);
         if (loaded[k]) return k;
      end
      if (fill_up > 0) return $urandom_range(0, fill_up - 1);
      return 0;
   endfunction

   task automatic random_item();
      int lo, hi, run, k;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            // fill from both ends, plus scattered writes
            case ($urandom_range(0, 3))
               0, 1: k = fill_up;
               2:    k = fill_down;
               default: k = $urandom_range(0, NPTS - 1);
            endcase
            while (k < NPTS && k >= 0 && loaded[k] && (k == fill_up || k == fill_down)) begin
               if (k == fill_up) begin
                  fill_up++;
                  k = fill_up;
               end else begin
                  fill_down--;
                  k = fill_down;
               end
            end
            if (k < 0 || k >= NPTS) k = $urandom_range(0, NPTS - 1);
            load_x(k, ($urandom_range(0, 1) == 0) ? 32'($urandom)
                                                  : 32'(k * 64 - 30000 + $urandom_range(0, 60)));
         end
         3, 4, 5, 6: begin
            lo = pick_loaded();
            run = 0;
            while (lo + run < NPTS && loaded[lo + run]) run++;
            if (run == 0) run = 1;
            hi = lo + (($urandom_range(0, 2) == 0) ? $urandom_range(1, run)
                                                   : $urandom_range(1, (run < 16) ? run : 16));
            if (!loaded[lo]) hi = lo;
            push_line(rand_slope(), rand_icpt(), lo, hi);
         end
         7, 8: begin
            query_min(pick_loaded());
         end
         default: begin
            // noise: unused code or an empty or reversed push
            if ($urandom_range(0, 1) == 0) begin
               send_item(FUNC_NONE, 10'($urandom), 32'($urandom), 32'($urandom),
                         64'({$urandom, $urandom}), 11'($urandom), 11'($urandom));
            end else begin
               hi = $urandom_range(0, NPTS);
               lo = $urandom_range(hi, NPTS);
               push_line(rand_slope(), rand_icpt(), lo, hi);
            end
         end
      endcase
   endtask

   initial begin
      int wait_cycles;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= FUNC_NONE;
      req_index     <= '0;
      req_x_value   <= '0;
      req_slope     <= '0;
      req_intercept <= '0;
      req_range_lo  <= '0;
      req_range_hi  <= '0;
      burst_left    = 0;
      fill_up       = 4;
      fill_down     = NPTS - 2;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: x extremes at the start of the table, plus its last entry
      load_x(0, 32'sh8000_0000);
      load_x(1, -32'sd1);
      load_x(2, 32'sd0);
      load_x(3, 32'sh7FFF_FFFF);
      load_x(NPTS - 1, 32'sd5);
      // empty tree answers the empty value
      query_min(0);
      query_min(NPTS - 1);
      // saturation corner: -2^31 * -2^31 + 2^62
      push_line(32'sh8000_0000, IC_TOP, 0, 1);
      query_min(0);
      // opposite extremes over a short range
      push_line(32'sh7FFF_FFFF, -IC_TOP, 0, 4);
      query_min(0);
      query_min(1);
      query_min(3);
      // empty and reversed ranges, unused code
      push_line(32'sd1, 64'sd0, 2, 2);
      push_line(32'sd1, 64'sd0, 3, 1);
      push_line(32'sd1, 64'sd0, NPTS, 0);
      send_item(FUNC_NONE, 10'h3FF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, IC_TOP,
                11'h7FF, 11'h7FF);
      // last entry, range ending at the table top
      push_line(-32'sd3, 64'sd7, NPTS - 1, NPTS);
      query_min(NPTS - 1);
      push_line(32'sd2, -64'sd9, 1, 3);
      query_min(2);

      repeat (800) random_item();

      // drop valid at the edge that took the last item
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (board.owed_min.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.owed_min.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (board.owed_min.size() != 0)
            $error("%0d result items never arrived", board.owed_min.size());
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit: far beyond the slowest legal run
   initial begin
      #200ms;
      $error("run limit reached");
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
src/lcmt_pkg.sv
src/lcmt_line_eval.sv
src/li_chao_min_line_tree_top.sv
bench/tb_top.sv
